>>> sv/sender_value_pool_table_top_macros.svh
// assertion macros shared by the pool table modules
`ifndef SENDER_VALUE_POOL_TABLE_TOP_MACROS_SVH
`define SENDER_VALUE_POOL_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define SVPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define SVPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SVPT_ASSERT(lbl, prop, msg)
`define SVPT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/svpt_pkg.sv
package svpt_pkg;

    localparam int TABLE_ENTRIES_DEF   = 20;
    localparam int SLOTS_PER_ENTRY_DEF = 5;
    localparam int ADDR_BITS_DEF       = 16;

    localparam int SENDER_ADDR_W = 16;
    localparam int DATA_BYTE_W   = 8;

    typedef enum logic [1:0] {
        OUT_NEW     = 2'd0,
        OUT_STORED  = 2'd1,
        OUT_FULL    = 2'd2,
        OUT_DROPPED = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [SENDER_ADDR_W-1:0] sender_addr;
        logic [DATA_BYTE_W-1:0]   data_byte;
    } t_req_item;

    typedef struct packed {
        t_outcome   outcome;
        logic [4:0] entry_index;
        logic [2:0] slot_index;
        logic       send_reply;
        logic [2:0] reply_byte;
        logic [7:0] first_value;
    } t_res_item;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic look;
        logic wr;
        logic any_hit;
    } t_cell_ctl;

    // what one cell hands to its right-hand neighbour
    typedef struct packed {
        logic      hit;
        logic      valid;
        logic      taken;
        t_res_item res;
    } t_link;

endpackage

>>> sv/svpt_cell.sv
`include "sender_value_pool_table_top_macros.svh"

module svpt_cell
    import svpt_pkg::*;
#(
    parameter int ENTRY_IDX = 0,
    parameter int SLOTS     = SLOTS_PER_ENTRY_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [ADDR_BITS-1:0] i_key,
    input  logic [7:0]           i_byte,
    input  t_link                i_link,
    output t_link                o_link
);

    localparam int SLOT_W = $clog2(SLOTS);

    logic                 r_valid;
    logic                 r_hit;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0]           r_slot [SLOTS];

    logic              hit_now;
    logic              alloc;
    logic              found;
    logic [SLOT_W-1:0] fidx;
    logic              last;
    t_res_item         own;
    logic              own_taken;

    assign hit_now = r_valid && (r_addr == i_key);
    // entries fill in index order: the first free cell after a used one allocates
    assign alloc   = i_ctl.wr && !i_ctl.any_hit && !r_valid && i_link.valid;

    // first empty slot among 1..SLOTS-1
    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int s = SLOTS - 1; s >= 1; s--) begin
            if (r_slot[s] == 8'd0) begin
                found = 1'b1;
                fidx  = SLOT_W'(s);
            end
        end
    end

    assign last = (fidx == SLOT_W'(SLOTS - 1));

    always_comb begin
        own       = '0;
        own_taken = 1'b0;
        if (i_ctl.wr && r_hit) begin
            own_taken        = 1'b1;
            own.entry_index  = 5'(ENTRY_IDX);
            own.first_value  = r_slot[0];
            if (found) begin
                own.outcome    = OUT_STORED;
                own.slot_index = 3'(fidx);
                own.send_reply = last;
                own.reply_byte = last ? 3'(fidx) : 3'd0;
            end else begin
                own.outcome    = OUT_FULL;
            end
        end else if (alloc) begin
            own_taken       = 1'b1;
            own.outcome     = OUT_NEW;
            own.entry_index = 5'(ENTRY_IDX);
            own.first_value = i_byte;
        end
    end

    assign o_link.hit   = i_link.hit | hit_now;
    assign o_link.valid = r_valid;
    assign o_link.taken = i_link.taken | own_taken;
    assign o_link.res   = i_link.res | own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_slot[s] <= 8'd0;
            end
        end else begin
            if (i_ctl.look) begin
                r_hit <= hit_now;
            end
            if (alloc) begin
                r_valid   <= 1'b1;
                r_slot[0] <= i_byte;
            end else if (i_ctl.wr && r_hit && found) begin
                r_slot[fidx] <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_addr <= i_key;
        end
    end

    `SVPT_ASSERT(a_fill_in_order, r_valid |-> i_link.valid, "cell used before its left neighbour")
    `SVPT_ASSERT(a_alloc_records, alloc |=> (r_valid && r_addr == $past(i_key)), "allocation lost")
    `SVPT_ASSERT(a_alloc_only_on_miss, $rose(r_valid) |-> ($past(i_ctl.wr) && !$past(i_ctl.any_hit)), "entry taken on a hit")

endmodule

>>> sv/sender_value_pool_table_top.sv
// channel   direction  handshake                      payload
// request   in         i_req_valid / o_req_ready      i_req  (t_req_item)
// result    out        o_res_valid / i_res_ready      o_res  (t_res_item)
//
// one request passes from acceptance to its result through accept, search, update and
// hand-over; the span is set by the cell row's compare and update steps
// a new request is taken only once the previous one has reached the output register
// the result waits in the output register while the next request is searched
// synchronous active-low reset empties the table and clears all slot values at once
// a stalled result holds the sequencer in hand-over until the output register frees

`include "sender_value_pool_table_top_macros.svh"

module sender_value_pool_table_top
    import svpt_pkg::*;
#(
    parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
    parameter int SLOTS_PER_ENTRY = SLOTS_PER_ENTRY_DEF,
    parameter int ADDR_BITS       = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  t_req_item i_req,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_res_item o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_WR   = 4'b0100,
        S_PEND = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_BITS-1:0] r_key;
    logic [7:0]           r_byte;
    logic                 r_any_hit;
    t_res_item            r_pend;
    t_res_item            r_out;
    logic                 r_out_valid;

    logic [ADDR_BITS+SENDER_ADDR_W-1:0] key_wide;
    logic                               req_acc;
    logic                               out_free;
    t_cell_ctl                          ctl;
    t_link                              w_link [TABLE_ENTRIES+1];
    t_res_item                          dropped;

    // only the low ADDR_BITS bits of the sender address take part, zero-extended if wider
    assign key_wide = {{ADDR_BITS{1'b0}}, i_req.sender_addr};

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign ctl.look    = (r_state == S_LOOK);
    assign ctl.wr      = (r_state == S_WR);
    assign ctl.any_hit = r_any_hit;

    always_comb begin
        dropped         = '0;
        dropped.outcome = OUT_DROPPED;
    end

    // left end of the row: nothing found yet, virtual used entry so cell 0 can allocate
    always_comb begin
        w_link[0]       = '0;
        w_link[0].valid = 1'b1;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        svpt_cell #(
            .ENTRY_IDX (g),
            .SLOTS     (SLOTS_PER_ENTRY),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_key   (r_key),
            .i_byte  (r_byte),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_WR;
            S_WR:   n_state = S_PEND;
            S_PEND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PEND && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_key  <= key_wide[ADDR_BITS-1:0];
            r_byte <= i_req.data_byte;
        end
        if (r_state == S_LOOK) begin
            r_any_hit <= w_link[TABLE_ENTRIES].hit;
        end
        // no cell answered: unknown sender and table full
        if (r_state == S_WR) begin
            r_pend <= w_link[TABLE_ENTRIES].taken ? w_link[TABLE_ENTRIES].res : dropped;
        end
        if (r_state == S_PEND && out_free) begin
            r_out <= r_pend;
        end
    end

    `SVPT_ASSERT(a_four_cycles, req_acc |-> ##3 (r_state == S_PEND), "request did not reach hand-over")
    `SVPT_ASSERT(a_handover, (r_state == S_PEND && out_free) |=> o_res_valid, "result not presented")
    `SVPT_ASSERT(a_drop_when_full, (r_state == S_WR && !w_link[TABLE_ENTRIES].taken) |-> w_link[TABLE_ENTRIES].valid, "request dropped with free entry")
    `SVPT_ASSERT_ALWAYS(a_state_onehot, $onehot(r_state) || !i_rst_n || $past(!i_rst_n), "sequencer state not one-hot")

endmodule
